[hw/rtl/positional_byte_list_core_defines.svh]
// ----------------------------------------------------------------------------
// positional_byte_list_core_defines.svh
// Assertion macros used by the list core checker.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_BYTE_LIST_CORE_DEFINES_SVH
`define POSITIONAL_BYTE_LIST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pbl_pkg.sv]
// ----------------------------------------------------------------------------
// pbl_pkg
// Types, widths and codes of the positional byte list core.
// ----------------------------------------------------------------------------
package pbl_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;

    localparam int CMD_W    = 3;
    localparam int VAL_W    = 8;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int FOUND_W  = 5;
    localparam int LEN_W    = 6;

    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(CAPACITY);

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_INS_FRONT = 3'd1,
        CMD_INS_POS   = 3'd2,
        CMD_REM_FIRST = 3'd3,
        CMD_REM_POS   = 3'd4,
        CMD_FIND      = 3'd5,
        CMD_CLEAR     = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef struct packed {
        status_t            status;
        logic [FOUND_W-1:0] found_index;
        logic [LEN_W-1:0]   length;
    } pbl_res_t;

endpackage

[hw/rtl/pbl_cmd_if.sv]
// ----------------------------------------------------------------------------
// pbl_cmd_if
// Command channel: valid/ready with one list command per item.
// ----------------------------------------------------------------------------
interface pbl_cmd_if
    import pbl_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [VAL_W-1:0]        item_value;
    logic signed [POS_W-1:0] slot_position;

    modport source (output valid, output command, output item_value,
                    output slot_position, input ready);
    modport sink   (input valid, input command, input item_value,
                    input slot_position, output ready);
endinterface

[hw/rtl/pbl_rsp_if.sv]
// ----------------------------------------------------------------------------
// pbl_rsp_if
// Response channel: valid/ready with one result per command.
// ----------------------------------------------------------------------------
interface pbl_rsp_if
    import pbl_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [FOUND_W-1:0]    found_index;
    logic [LEN_W-1:0]      length;

    modport source (output valid, output status, output found_index,
                    output length, input ready);
    modport sink   (input valid, input status, input found_index,
                    input length, output ready);
endinterface

[hw/rtl/pbl_ram.sv]
// ----------------------------------------------------------------------------
// pbl_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pbl_ram #(
    parameter int DEPTH  = 32,
    parameter int DATA_W = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] store_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= store_mem[raddr];
        end
    end

endmodule

[hw/rtl/pbl_seq.sv]
// ----------------------------------------------------------------------------
// pbl_seq
// Command sequencer: decodes a command, walks the entry RAM one entry per
// cycle to shift or search, and keeps the entry count.
// ----------------------------------------------------------------------------
module pbl_seq
    import pbl_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    pbl_cmd_if.sink        cmd,
    output logic           res_valid,
    input  logic           res_ready,
    output pbl_res_t       res,
    output logic           mem_we,
    output addr_t          mem_waddr,
    output logic [VAL_W-1:0] mem_wdata,
    output logic           mem_re,
    output addr_t          mem_raddr,
    input  logic [VAL_W-1:0] mem_rdata
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINAL, S_DONE} state_t;
    typedef enum logic [1:0] {M_UP, M_DOWN, M_FIND} mode_t;

    state_t             state_reg, state_next;
    cnt_t               count_reg, count_next;
    logic               issue_reg, issue_next;
    logic               pend_reg, pend_next;
    status_t            status_reg, status_next;
    logic [FOUND_W-1:0] found_reg, found_next;

    mode_t              mode_reg, mode_next;
    addr_t              rd_ptr_reg, rd_ptr_next;
    addr_t              end_ptr_reg, end_ptr_next;
    addr_t              pend_addr_reg, pend_addr_next;
    addr_t              pos_reg, pos_next;
    logic [VAL_W-1:0]   val_reg, val_next;

    logic               accept;
    logic               pos_neg;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   cnt_m1_ext;
    cnt_t               count_m1;
    addr_t              pos_a;
    logic               full;
    logic               empty;

    assign cmd.ready  = (state_reg == S_IDLE);
    assign accept     = cmd.valid && cmd.ready;
    assign pos_neg    = cmd.slot_position[POS_W-1];
    assign pos_ext    = CMP_W'(cmd.slot_position[POS_W-2:0]);
    assign cnt_ext    = CMP_W'(count_reg);
    assign count_m1   = count_reg - 1'b1;
    assign cnt_m1_ext = CMP_W'(count_m1);
    assign pos_a      = pos_ext[ADDR_W-1:0];
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign empty      = (count_reg == '0);

    assign res_valid       = (state_reg == S_DONE);
    assign res.status      = status_reg;
    assign res.found_index = found_reg;
    assign res.length      = LEN_W'(count_reg);

    // Shifts read one entry ahead of the write, walking away from it, so the
    // read and write ports never touch the same entry in one cycle.
    always_comb
    begin
        logic  do_ins;
        logic  ins_end;
        addr_t ins_at;
        logic  do_rem;
        logic  rem_last;
        addr_t rem_at;

        state_next     = state_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        status_next    = status_reg;
        found_next     = found_reg;
        mode_next      = mode_reg;
        rd_ptr_next    = rd_ptr_reg;
        end_ptr_next   = end_ptr_reg;
        pend_addr_next = pend_addr_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = val_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_ptr_reg;
        do_ins         = 1'b0;
        ins_end        = 1'b0;
        ins_at         = '0;
        do_rem         = 1'b0;
        rem_last       = 1'b0;
        rem_at         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = cmd.item_value;
                    status_next = ST_OK;
                    found_next  = '0;
                    state_next  = S_DONE;
                    case (cmd_t'(cmd.command))
                        CMD_APPEND:
                        begin
                            do_ins  = 1'b1;
                            ins_end = 1'b1;
                            ins_at  = count_reg[ADDR_W-1:0];
                        end
                        CMD_INS_FRONT:
                        begin
                            do_ins  = 1'b1;
                            ins_end = empty;
                            ins_at  = '0;
                        end
                        CMD_INS_POS:
                        begin
                            if (pos_neg || (pos_ext > cnt_ext))
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                do_ins  = 1'b1;
                                ins_end = (pos_ext == cnt_ext);
                                ins_at  = pos_a;
                            end
                        end
                        CMD_REM_FIRST:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                do_rem   = 1'b1;
                                rem_at   = '0;
                                rem_last = (count_m1 == '0);
                            end
                        end
                        CMD_REM_POS:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (pos_neg || (pos_ext >= cnt_ext))
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                do_rem   = 1'b1;
                                rem_at   = pos_a;
                                rem_last = (pos_ext == cnt_m1_ext);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mode_next    = M_FIND;
                                rd_ptr_next  = '0;
                                end_ptr_next = count_m1[ADDR_W-1:0];
                                issue_next   = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_ins)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            if (ins_end)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ins_at;
                                mem_wdata = cmd.item_value;
                            end
                            else
                            begin
                                mode_next    = M_UP;
                                rd_ptr_next  = count_m1[ADDR_W-1:0];
                                end_ptr_next = ins_at;
                                pos_next     = ins_at;
                                issue_next   = 1'b1;
                                state_next   = S_SCAN;
                            end
                        end
                    end

                    if (do_rem)
                    begin
                        count_next = count_m1;
                        if (!rem_last)
                        begin
                            mode_next    = M_DOWN;
                            rd_ptr_next  = rem_at + 1'b1;
                            end_ptr_next = count_m1[ADDR_W-1:0];
                            issue_next   = 1'b1;
                            state_next   = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN:
            begin
                if (issue_reg)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = rd_ptr_reg;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    if (rd_ptr_reg == end_ptr_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else if (mode_reg == M_UP)
                    begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + 1'b1;
                    end
                end

                if (pend_reg)
                begin
                    unique case (mode_reg)
                        M_UP:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg + 1'b1;
                            mem_wdata = mem_rdata;
                            if (!issue_reg)
                            begin
                                state_next = S_FINAL;
                            end
                        end
                        M_DOWN:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pend_addr_reg - 1'b1;
                            mem_wdata = mem_rdata;
                            if (!issue_reg)
                            begin
                                state_next = S_DONE;
                            end
                        end
                        M_FIND:
                        begin
                            if (mem_rdata == val_reg)
                            begin
                                status_next = ST_OK;
                                found_next  = FOUND_W'(pend_addr_reg);
                                issue_next  = 1'b0;
                                pend_next   = 1'b0;
                                state_next  = S_DONE;
                            end
                            else if (!issue_reg)
                            begin
                                status_next = ST_NOTFOUND;
                                state_next  = S_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FINAL:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            issue_reg  <= 1'b0;
            pend_reg   <= 1'b0;
            status_reg <= ST_OK;
            found_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            issue_reg  <= issue_next;
            pend_reg   <= pend_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        rd_ptr_reg    <= rd_ptr_next;
        end_ptr_reg   <= end_ptr_next;
        pend_addr_reg <= pend_addr_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
    end

endmodule

[hw/rtl/positional_byte_list_core.sv]
// ----------------------------------------------------------------------------
// positional_byte_list_core
// Bounded ordered byte list held in a one-port-read, one-port-write RAM.
//
//   channel  dir  payload
//   cmd      in   command, item_value, slot_position
//   rsp      out  status, found_index, length
//
// Append, insert at the end and clear go from accept straight to the done state.
// Inserts elsewhere walk the entries from the slot up, one per cycle over the RAM
// read/write ports, then write the item; removes shift the entries above the slot
// down; find reads from index 0 up and stops at the first hit.
// Reset clears the entry count, not the RAM; RAM contents are never read unwritten.
// A new command is taken while the previous result waits in the output register;
// a stalled rsp holds the sequencer once both are full.
// ----------------------------------------------------------------------------
module positional_byte_list_core
    import pbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    pbl_cmd_if.sink  cmd,
    pbl_rsp_if.source rsp
);

    logic             res_valid;
    logic             res_ready;
    pbl_res_t         res;
    logic             mem_we;
    addr_t            mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic             mem_re;
    addr_t            mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    logic             out_valid_reg, out_valid_next;
    pbl_res_t         out_data_reg;

    pbl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    pbl_ram #(
        .DEPTH  (CAPACITY),
        .DATA_W (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.found_index = out_data_reg.found_index;
    assign rsp.length      = out_data_reg.length;

endmodule

[hw/rtl/pbl_checker.sv]
// ----------------------------------------------------------------------------
// pbl_checker
// Port-level checks of the list core, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_byte_list_core_defines.svh"

module pbl_checker
    import pbl_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [FOUND_W-1:0]  rsp_found_index,
    input logic [LEN_W-1:0]    rsp_length
);

    // items accepted but not yet answered: one in the sequencer, one in the
    // output register at most
    logic [1:0] open_reg, open_next;

    always_comb
    begin
        open_next = open_reg;
        if ((cmd_valid && cmd_ready) && !(rsp_valid && rsp_ready))
        begin
            open_next = open_reg + 1'b1;
        end
        else if (!(cmd_valid && cmd_ready) && (rsp_valid && rsp_ready))
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    `PBL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_index) && $stable(rsp_length), "rsp item changed while stalled")
    `PBL_ASSERT_SAME(a_no_orphan, rsp_valid, open_reg != 2'd0, "result with no open item")
    `PBL_ASSERT_SAME(a_open_bound, 1'b1, open_reg <= 2'd2, "more than two items open")
    `PBL_ASSERT_SAME(a_full_len, rsp_valid && (rsp_status == ST_FULL), rsp_length == LEN_FULL, "full status with short list")
    `PBL_ASSERT_SAME(a_empty_len, rsp_valid && (rsp_status == ST_EMPTY), (rsp_length == '0) && (rsp_found_index == '0), "empty status with entries")

endmodule

bind positional_byte_list_core pbl_checker u_pbl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_found_index (rsp.found_index),
    .rsp_length      (rsp.length)
);
